@@ rtl/sse_pkg.sv @@
// Shared types and codes for the set-of-stacks engine.
// No dependencies; used by sse_ctrl, sse_datapath and set_of_stacks_engine.
package sse_pkg;

    localparam int LIMIT_W = 3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
        logic [3:0]         stack_index;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the command beat
        logic exec;     // update slot map / fills, access value RAM
        logic respond;  // result beat on the output
    } sse_ctrl_t;

endpackage

@@ rtl/sse_ctrl.sv @@
// Sequencing controller for the set-of-stacks engine.
// Depends on sse_pkg (sse_ctrl_t).
module sse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output sse_pkg::sse_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                S_RESP:
                begin
                    done_reg <= 1'b0;
                    // next command may enter while the result beat is out
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign ctrl.capture = accept;
    assign ctrl.exec    = (state_reg == S_EXEC);
    assign ctrl.respond = done_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle not followed by result beat");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding execute cycle");

    a_exec_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec == busy)
        else $error("execute strobe and busy disagree");

endmodule

@@ rtl/sse_datapath.sv @@
// Datapath for the set-of-stacks engine: slot map, fill counts, value RAM.
// Depends on sse_pkg (cmd_t, result_t, sse_ctrl_t, opcode/status codes).
module sse_datapath #(
    parameter int SUBSTACK_CAP  = 4,
    parameter int MAX_SUBSTACKS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sse_pkg::sse_ctrl_t           ctrl,
    input  sse_pkg::cmd_t                cmd,
    input  logic                         cfg_we,
    input  logic [sse_pkg::LIMIT_W-1:0]  cfg_data,
    output sse_pkg::result_t             result
);

    localparam int SLOT_W = (MAX_SUBSTACKS > 1) ? $clog2(MAX_SUBSTACKS) : 1;
    localparam int LIVE_W = $clog2(MAX_SUBSTACKS + 1);
    localparam int FILL_W = $clog2(SUBSTACK_CAP + 1);
    localparam int DEPTH  = MAX_SUBSTACKS * SUBSTACK_CAP;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = LIVE_W + 4;

    sse_pkg::cmd_t                 cmd_reg;
    logic [sse_pkg::LIMIT_W-1:0]   limit_reg;
    logic [SLOT_W-1:0]             order_reg [MAX_SUBSTACKS];
    logic [SLOT_W-1:0]             order_next [MAX_SUBSTACKS];
    logic [FILL_W-1:0]             fill_reg [MAX_SUBSTACKS];
    logic [FILL_W-1:0]             fill_next [MAX_SUBSTACKS];
    logic [LIVE_W-1:0]             live_reg;
    logic [LIVE_W-1:0]             live_next;
    logic [31:0]                   mem [DEPTH];
    logic [31:0]                   rd_data_reg;
    logic                          pop_ok_reg;
    logic [1:0]                    status_reg;

    logic              is_push;
    logic              is_pop;
    logic              is_pop_at;
    logic [FILL_W-1:0] eff_limit;
    logic              live_nz;
    logic              live_full;
    logic              idx_ok;
    logic [SLOT_W-1:0] last_pos;
    logic [SLOT_W-1:0] new_pos;
    logic [SLOT_W-1:0] take_pos;
    logic [SLOT_W-1:0] phys_last;
    logic [SLOT_W-1:0] phys_new;
    logic [SLOT_W-1:0] phys_take;
    logic [FILL_W-1:0] fill_last;
    logic [FILL_W-1:0] fill_take;
    logic [FILL_W-1:0] fill_after;
    logic              open_new;
    logic              push_ok;
    logic [SLOT_W-1:0] push_phys;
    logic [FILL_W-1:0] push_fill;
    logic              push_wr;
    logic              take;
    logic              take_rd;
    logic              take_remove;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        status_next;

    always_comb
    begin
        is_push   = 1'b0;
        is_pop    = 1'b0;
        is_pop_at = 1'b0;
        unique case (cmd_reg.opcode)
            sse_pkg::OP_PUSH:   is_push   = 1'b1;
            sse_pkg::OP_POP:    is_pop    = 1'b1;
            sse_pkg::OP_POP_AT: is_pop_at = 1'b1;
            default:            ;   // reserved opcode: no change
        endcase
    end

    // limit clamped to 1..SUBSTACK_CAP
    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = FILL_W'(1);
        else if (int'(limit_reg) > SUBSTACK_CAP)
            eff_limit = FILL_W'(SUBSTACK_CAP);
        else
            eff_limit = FILL_W'(limit_reg);
    end

    assign live_nz   = (live_reg != '0);
    assign live_full = (live_reg == LIVE_W'(MAX_SUBSTACKS));
    assign idx_ok    = CMP_W'(cmd_reg.stack_index) < CMP_W'(live_reg);
    assign last_pos  = SLOT_W'(live_reg - LIVE_W'(1));
    assign new_pos   = live_full ? '0 : SLOT_W'(live_reg);
    assign take_pos  = is_pop_at ? SLOT_W'(cmd_reg.stack_index) : last_pos;

    assign phys_last = order_reg[last_pos];
    assign phys_new  = order_reg[new_pos];
    assign phys_take = order_reg[take_pos];
    assign fill_last = fill_reg[phys_last];
    assign fill_take = fill_reg[phys_take];

    // push
    assign open_new  = !live_nz || (fill_last >= eff_limit);
    assign push_ok   = is_push && !(open_new && live_full);
    assign push_phys = open_new ? phys_new : phys_last;
    assign push_fill = open_new ? '0 : fill_last;
    assign push_wr   = push_ok && (int'(push_fill) < SUBSTACK_CAP);
    assign wr_addr   = ADDR_W'(int'(push_phys) * SUBSTACK_CAP + int'(push_fill));

    // pop / pop-at
    assign take        = (is_pop && live_nz) || (is_pop_at && idx_ok);
    assign fill_after  = (fill_take != '0) ? fill_take - FILL_W'(1) : '0;
    assign take_rd     = take && (fill_take != '0) && (int'(fill_after) < SUBSTACK_CAP);
    assign take_remove = take && (fill_after == '0);
    assign rd_addr     = ADDR_W'(int'(phys_take) * SUBSTACK_CAP + int'(fill_after));

    always_comb
    begin
        if (is_push && !push_ok)
            status_next = sse_pkg::ST_FULL;
        else if (is_pop && !live_nz)
            status_next = sse_pkg::ST_EMPTY;
        else if (is_pop_at && !idx_ok)
            status_next = sse_pkg::ST_BADIDX;
        else
            status_next = sse_pkg::ST_OK;
    end

    always_comb
    begin
        order_next = order_reg;
        fill_next  = fill_reg;
        live_next  = live_reg;
        if (push_ok)
        begin
            if (push_wr)
                fill_next[push_phys] = push_fill + FILL_W'(1);
            else
                fill_next[push_phys] = push_fill;
            if (open_new)
                live_next = live_reg + LIVE_W'(1);
        end
        if (take)
        begin
            fill_next[phys_take] = fill_after;
            if (take_remove)
            begin
                // close the gap, emptied slot goes to the end of the live range
                for (int k = 0; k < MAX_SUBSTACKS - 1; k++)
                begin
                    if (SLOT_W'(k) >= take_pos && LIVE_W'(k + 1) < live_reg)
                        order_next[k] = order_reg[k + 1];
                end
                order_next[last_pos] = phys_take;
                live_next = live_reg - LIVE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= sse_pkg::LIMIT_RESET;
            live_reg  <= '0;
            for (int i = 0; i < MAX_SUBSTACKS; i++)
            begin
                order_reg[i] <= SLOT_W'(i);
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (ctrl.exec)
            begin
                live_reg  <= live_next;
                order_reg <= order_next;
                fill_reg  <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            cmd_reg <= cmd;
        if (ctrl.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= take_rd;
        end
    end

    // value RAM: one write or one registered read per execute cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && push_wr)
            mem[wr_addr] <= cmd_reg.push_value;
        if (ctrl.exec && take_rd)
            rd_data_reg <= mem[rd_addr];
    end

    assign result.pop_value = (ctrl.respond && pop_ok_reg) ? $signed(rd_data_reg) : '0;
    assign result.status    = status_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(MAX_SUBSTACKS))
        else $error("live sub-stack count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && push_ok && open_new |=> live_reg == $past(live_reg) + LIVE_W'(1))
        else $error("opening a sub-stack did not bump the live count");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && take_remove |=> live_reg == $past(live_reg) - LIVE_W'(1))
        else $error("emptied sub-stack not removed");

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && push_ok |-> int'(push_fill) < SUBSTACK_CAP)
        else $error("push into a sub-stack already at capacity");

endmodule

@@ rtl/set_of_stacks_engine.sv @@
// Set-of-stacks engine: chain of bounded sub-stacks with push, pop and pop-at.
// A taken command is executed in S_EXEC and gives its result beat (done) in S_RESP.
// No command is taken while busy (S_EXEC); start is taken again during the result beat.
// S_EXEC covers the value RAM's registered read and the fill/slot-map update.
// Reset (rst_n, async low): all sub-stacks empty, identity slot map, stack_limit = 4;
// the value RAM is not cleared. The receiver cannot stall; done lasts one cycle.
module set_of_stacks_engine #(
    parameter int SUBSTACK_CAP  = 4,
    parameter int MAX_SUBSTACKS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sse_pkg::cmd_t                cmd,
    output logic                         done,
    output sse_pkg::result_t             result,
    input  logic                         cfg_we,
    input  logic [sse_pkg::LIMIT_W-1:0]  cfg_data
);

    sse_pkg::sse_ctrl_t ctrl;

    sse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    sse_datapath #(
        .SUBSTACK_CAP  (SUBSTACK_CAP),
        .MAX_SUBSTACKS (MAX_SUBSTACKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for set_of_stacks_engine: directed table, then random phases.
// Depends on rtl/sse_pkg.sv and rtl/set_of_stacks_engine.sv; carries its own predictor.
module tb_top;

    localparam int          CAP        = 4;
    localparam int          NSLOTS     = 16;
    localparam logic [1:0]  OP_RSVD    = 2'd3;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          N_PHASES   = 8;
    localparam int          PHASE_LEN  = 120;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    sse_pkg::cmd_t               cmd;
    logic                        done;
    sse_pkg::result_t            result;
    logic                        cfg_we;
    logic [sse_pkg::LIMIT_W-1:0] cfg_data;

    // predictor state
    logic [3:0]                  stack_order [NSLOTS];
    logic [2:0]                  stack_fill  [NSLOTS];
    int                          live_cnt;
    logic [31:0]                 val_mem     [NSLOTS*CAP];
    logic [sse_pkg::LIMIT_W-1:0] limit_q;

    sse_pkg::result_t            expected_results [$];
    int                          errors;
    int                          idle_cycles;

    typedef struct packed {
        bit                          is_cfg;
        logic [sse_pkg::LIMIT_W-1:0] lim;
        logic [1:0]                  op;
        logic [31:0]                 val;
        logic [3:0]                  idx;
        int                          reps;
        bit                          chk;
        logic [31:0]                 want_val;
        logic [1:0]                  want_st;
    } plan_row_t;

    plan_row_t plan [24] = '{
        '{1'b0, 3'd0, sse_pkg::OP_POP,    32'h0,        4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_EMPTY},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_BADIDX},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd15, 1,  1'b1, 32'h0,
          sse_pkg::ST_BADIDX},
        '{1'b0, 3'd0, OP_RSVD,            32'hFFFFFFFF, 4'd15, 1,  1'b1, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'h7FFFFFFF, 4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'h80000000, 4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'h00000000, 4'd0,  3,  1'b1, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd1,  1,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd1,  1,  1'b1, 32'h0,
          sse_pkg::ST_BADIDX},
        '{1'b0, 3'd0, sse_pkg::OP_POP,    32'h0,        4'd0,  4,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP,    32'h0,        4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_EMPTY},
        // limit 0 behaves as 1: one value per sub-stack
        '{1'b1, 3'd0, sse_pkg::OP_PUSH,   32'h0,        4'd0,  0,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'h5A5A5A5A, 4'd0,  16, 1'b1, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'h12345678, 4'd0,  1,  1'b1, 32'h0,
          sse_pkg::ST_FULL},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd15, 1,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd7,  1,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd0,  1,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        // 7 clamps to the sub-stack capacity
        '{1'b1, 3'd7, sse_pkg::OP_PUSH,   32'h0,        4'd0,  0,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'hA5A5A5A5, 4'd0,  10, 1'b0, 32'h0,
          sse_pkg::ST_OK},
        // lower the limit while sub-stacks hold more than it
        '{1'b1, 3'd2, sse_pkg::OP_PUSH,   32'h0,        4'd0,  0,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_PUSH,   32'hC0FFEE00, 4'd0,  3,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP_AT, 32'h0,        4'd0,  4,  1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b0, 3'd0, sse_pkg::OP_POP,    32'h0,        4'd0,  30, 1'b0, 32'h0,
          sse_pkg::ST_OK},
        '{1'b1, 3'd4, sse_pkg::OP_PUSH,   32'h0,        4'd0,  0,  1'b0, 32'h0,
          sse_pkg::ST_OK}
    };

    logic [sse_pkg::LIMIT_W-1:0] phase_limit [N_PHASES] =
        '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd1};
    int                          phase_push  [N_PHASES] = '{75, 40, 80, 70, 35, 60, 45, 85};

    set_of_stacks_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // take the top of the sub-stack at a live logical position; drop it once empty
    function automatic logic [31:0] pop_top(input int pos);
        int          phys;
        int          f;
        logic [31:0] v;
        phys = int'(stack_order[pos]);
        f    = int'(stack_fill[phys]);
        v    = '0;
        if (f > 0)
        begin
            f--;
            v = val_mem[phys*CAP + f];
            stack_fill[phys] = f[2:0];
        end
        if (f == 0)
        begin
            for (int k = pos; k + 1 < live_cnt; k++)
                stack_order[k] = stack_order[k+1];
            stack_order[live_cnt-1] = phys[3:0];
            live_cnt--;
        end
        return v;
    endfunction

    function automatic sse_pkg::result_t predict_stack_op(input sse_pkg::cmd_t c);
        sse_pkg::result_t r;
        int               lim;
        int               phys;
        int               f;
        bit               open_new;
        r.pop_value = '0;
        r.status    = sse_pkg::ST_OK;
        lim = (limit_q == 0) ? 1 : ((limit_q > CAP) ? CAP : int'(limit_q));
        case (c.opcode)
            sse_pkg::OP_PUSH:
            begin
                phys     = 0;
                open_new = 1'b1;
                if (live_cnt > 0)
                begin
                    phys = int'(stack_order[live_cnt-1]);
                    if (int'(stack_fill[phys]) < lim)
                        open_new = 1'b0;
                end
                if (open_new)
                begin
                    if (live_cnt >= NSLOTS)
                        r.status = sse_pkg::ST_FULL;
                    else
                    begin
                        phys = int'(stack_order[live_cnt]);
                        stack_fill[phys] = '0;
                        live_cnt++;
                    end
                end
                if (r.status == sse_pkg::ST_OK)
                begin
                    f = int'(stack_fill[phys]);
                    if (f < CAP)
                    begin
                        val_mem[phys*CAP + f] = c.push_value;
                        stack_fill[phys] = 3'(f + 1);
                    end
                end
            end
            sse_pkg::OP_POP:
            begin
                if (live_cnt == 0)
                    r.status = sse_pkg::ST_EMPTY;
                else
                    r.pop_value = pop_top(live_cnt - 1);
            end
            sse_pkg::OP_POP_AT:
            begin
                if (int'(c.stack_index) >= live_cnt)
                    r.status = sse_pkg::ST_BADIDX;
                else
                    r.pop_value = pop_top(int'(c.stack_index));
            end
            default: ;
        endcase
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic issue(input sse_pkg::cmd_t c, input bit use_want,
                         input sse_pkg::result_t want);
        sse_pkg::result_t r;
        start = 1'b1;
        cmd   = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_stack_op(c);
        expected_results = {expected_results, (use_want ? want : r)};
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [sse_pkg::LIMIT_W-1:0] v);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = v;
        limit_q  = v;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        sse_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat pop_value=%h status=%0d",
                             $time, result.pop_value, result.status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pop_value !== want.pop_value)
                    begin
                        $display("%0t: pop_value expected %h actual %h",
                                 $time, want.pop_value, result.pop_value);
                        errors++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result.status);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("set_of_stacks_engine test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        sse_pkg::cmd_t    c;
        sse_pkg::result_t want;
        int               burst_left;
        int               gap;
        int               r;
        int               pct;

        errors      = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        limit_q     = sse_pkg::LIMIT_RESET;
        live_cnt    = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            stack_order[i] = i[3:0];
            stack_fill[i]  = '0;
        end
        for (int i = 0; i < NSLOTS*CAP; i++)
            val_mem[i] = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_limit(plan[i].lim);
            else
            begin
                for (int k = 0; k < plan[i].reps; k++)
                begin
                    c.opcode      = plan[i].op;
                    c.push_value  = plan[i].val + 32'(k);
                    c.stack_index = plan[i].idx;
                    want.pop_value = plan[i].want_val;
                    want.status    = plan[i].want_st;
                    issue(c, plan[i].chk, want);
                end
            end
        end

        burst_left = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // phases 1 and 4 run back to back with no gaps
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = (p == 1 || p == 4 || $urandom_range(0, 3) == 0) ? 0
                                                                          : $urandom_range(1, 7);
                    if (gap > 0)
                    begin
                        start = 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                burst_left--;

                pct           = phase_push[p];
                r             = $urandom_range(0, 99);
                c.push_value  = $urandom;
                c.stack_index = 4'($urandom_range(0, 15));
                if (r < pct)
                    c.opcode = sse_pkg::OP_PUSH;
                else if (r < pct + (100 - pct) / 2)
                    c.opcode = sse_pkg::OP_POP;
                else if (r < 97)
                begin
                    c.opcode = sse_pkg::OP_POP_AT;
                    if (live_cnt > 0 && $urandom_range(0, 3) != 0)
                        c.stack_index = 4'($urandom_range(0, live_cnt - 1));
                end
                else
                    c.opcode = OP_RSVD;
                want = '0;
                issue(c, 1'b0, want);
            end
        end

        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("set_of_stacks_engine test passed");
        else
            $display("set_of_stacks_engine test failed");
        $finish;
    end

endmodule
